[src/m5ird_pkg.sv]
// Shared types and constants for the median-of-five distance unit.
package m5ird_pkg;

    localparam int SampleW  = 10;
    localparam int CmW      = 5;
    localparam int MmW      = 9;
    localparam int QuotW    = 9;
    localparam int GroupLen = 5;
    localparam int PosW     = $clog2(GroupLen);
    localparam int CntW     = $clog2(SampleW);
    localparam int NumerW   = 15;
    localparam int RemInitW = NumerW - QuotW;
    localparam int RecipW   = 8;
    localparam int ProdW    = QuotW + RecipW;
    localparam int RecipShift = 11;
    localparam int TensW    = ProdW - RecipShift;

    localparam logic [SampleW-1:0]  NearLimit = 10'd574;
    localparam logic [SampleW-1:0]  FarLimit  = 10'd81;
    localparam logic [NumerW-1:0]   MmNumer   = 15'd23552;
    localparam logic [RemInitW-1:0] RemInit   = MmNumer[NumerW-1:QuotW];
    localparam logic [RecipW-1:0]   Recip10   = 8'd205;
    localparam logic [CmW-1:0]      CmNear    = 5'd2;
    localparam logic [CmW-1:0]      CmFar     = 5'd30;
    localparam logic [MmW-1:0]      MmMin     = 9'd40;
    localparam logic [MmW-1:0]      MmFar     = 9'd300;
    localparam logic [PosW-1:0]     LastPos   = PosW'(GroupLen - 1);
    localparam logic [2:0]          MedRank   = 3'd2;

    typedef logic [SampleW-1:0] sample_t;
    typedef logic [CmW-1:0]     cm_t;
    typedef logic [MmW-1:0]     mm_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SELECT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

[src/m5ird_if.sv]
// Valid/ready channel interfaces for samples and results.
interface m5ird_sample_if;
    import m5ird_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface m5ird_result_if;
    import m5ird_pkg::*;

    logic    valid;
    logic    ready;
    sample_t median_raw;
    cm_t     distance_cm;
    mm_t     distance_mm;

    modport source (output valid, output median_raw, output distance_cm,
                    output distance_mm, input ready);
    modport sink   (input valid, input median_raw, input distance_cm,
                    input distance_mm, output ready);
endinterface

[src/median5_ir_distance_unit.sv]
// Median-of-five filter with bit-serial rank selection and reciprocal distance map.
//
//  Channel   Direction  Payload                                   Transfer when
//  samples   in         sample (10b)                              valid && ready
//  results   out        median_raw (10b), distance_cm (5b),       valid && ready
//                       distance_mm (9b)
//
// The fifth sample of a group starts a serial pass: MSB-first rank selection
// for the median, a restoring divider for 23552/m, and a final load of the
// result. The sample port is ready only while collecting, so a new group is
// taken only after the pass ends; a stalled result waits in the output
// register, while the next group's five samples are still taken and its pass
// runs, holding in the finishing state until the output register is free.
// Reset (rst_n, asynchronous, active low) clears the group position, the
// sequencer and the result valid flag.
module median5_ir_distance_unit (
    input  logic           clk,
    input  logic           rst_n,
    m5ird_sample_if.sink   samples,
    m5ird_result_if.source results
);
    import m5ird_pkg::*;

    state_t                state_reg, state_next;
    logic [PosW-1:0]       pos_reg, pos_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    sample_t               sh_reg [GroupLen];
    sample_t               sh_next [GroupLen];
    logic [GroupLen-1:0]   alive_reg, alive_next;
    logic [2:0]            k_reg, k_next;
    sample_t               med_reg, med_next;
    sample_t               rem_reg, rem_next;
    logic [QuotW-1:0]      quot_reg, quot_next;
    logic                  out_valid_reg, out_valid_next;
    sample_t               out_med_reg;
    cm_t                   out_cm_reg;
    mm_t                   out_mm_reg;

    logic                  load_out;
    logic                  take_sample;
    logic [GroupLen-1:0]   msb_bits;
    logic [GroupLen-1:0]   zero_set;
    logic [2:0]            zero_cnt;
    logic                  bit_is_zero;
    logic [SampleW:0]      rem_shift;
    logic [SampleW+1:0]    rem_diff;
    logic                  quot_bit;
    logic [ProdW-1:0]      tens_prod;
    logic [TensW-1:0]      tens;
    logic                  is_far;
    logic                  is_near;
    cm_t                   cm_value;
    mm_t                   mm_value;

    // Handshake and load controls.
    always_comb
    begin
        samples.ready = (state_reg == ST_COLLECT);
        load_out      = (state_reg == ST_FINISH) && (!out_valid_reg || results.ready);
    end

    assign take_sample = samples.valid && samples.ready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (take_sample && pos_reg == LastPos)
                    state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (cnt_reg == CntW'(SampleW - 1))
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_out)
                    state_next = ST_COLLECT;
            end
            default:
                state_next = ST_COLLECT;
        endcase
    end

    // Rank selection looks at the top bit of every live candidate. If more
    // candidates than the wanted rank have a zero there, the median's bit is
    // zero and the ones drop out; otherwise the bit is one and the zeros drop
    // out, lowering the rank still wanted by their count.
    always_comb
    begin
        for (int p = 0; p < GroupLen; p++)
            msb_bits[p] = sh_reg[p][SampleW-1];
        zero_set    = alive_reg & ~msb_bits;
        zero_cnt    = 3'($countones(zero_set));
        bit_is_zero = (zero_cnt > k_reg);
    end

    // One restoring divider step; the low dividend bits come from the constant.
    always_comb
    begin
        rem_shift = {rem_reg, MmNumer[cnt_reg]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, med_reg};
        quot_bit  = !rem_diff[SampleW+1];
    end

    // Distance map. A median of 81 or less reads as far, which also keeps the
    // meaningless quotient of a tiny divisor off the outputs. Centimeters are
    // the millimeter quotient divided by ten through a reciprocal multiply.
    always_comb
    begin
        is_far    = (med_reg <= FarLimit);
        is_near   = (med_reg >= NearLimit);
        tens_prod = ProdW'(quot_reg) * ProdW'(Recip10);
        tens      = tens_prod[ProdW-1:RecipShift];
        if (is_near)
            cm_value = CmNear;
        else if (is_far || tens > TensW'(CmFar))
            cm_value = CmFar;
        else
            cm_value = CmW'(tens);
        if (is_far || quot_reg > MmFar)
            mm_value = MmFar;
        else if (quot_reg < MmMin)
            mm_value = MmMin;
        else
            mm_value = quot_reg;
    end

    // Datapath next values.
    always_comb
    begin
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        alive_next = alive_reg;
        k_next    = k_reg;
        med_next  = med_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (take_sample)
                begin
                    sh_next[pos_reg] = samples.sample;
                    if (pos_reg == LastPos)
                    begin
                        pos_next   = '0;
                        cnt_next   = '0;
                        alive_next = '1;
                        k_next     = MedRank;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_SELECT:
            begin
                for (int p = 0; p < GroupLen; p++)
                    sh_next[p] = {sh_reg[p][SampleW-2:0], 1'b0};
                med_next = {med_reg[SampleW-2:0], !bit_is_zero};
                if (bit_is_zero)
                begin
                    alive_next = zero_set;
                end
                else
                begin
                    alive_next = alive_reg & msb_bits;
                    k_next     = k_reg - zero_cnt;
                end
                if (cnt_reg == CntW'(SampleW - 1))
                begin
                    cnt_next = CntW'(QuotW - 1);
                    rem_next = SampleW'(RemInit);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = quot_bit ? rem_diff[SampleW-1:0] : rem_shift[SampleW-1:0];
                quot_next = {quot_reg[QuotW-2:0], quot_bit};
                cnt_next  = cnt_reg - 1'b1;
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        alive_reg <= alive_next;
        k_reg     <= k_next;
        med_reg   <= med_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        if (load_out)
        begin
            out_med_reg <= med_reg;
            out_cm_reg  <= cm_value;
            out_mm_reg  <= mm_value;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.median_raw  = out_med_reg;
    assign results.distance_cm = out_cm_reg;
    assign results.distance_mm = out_mm_reg;

endmodule
